[rtl/core/cbm_pkg.sv]
// cbm_pkg: shared types, codes and reset constants of the bank mapper
// depends on nothing; used by cbm_regs, cbm_map and the top level
package cbm_pkg;

   // bus item commands
   typedef enum logic [2:0] {
      CMD_REG_WRITE  = 3'd0,
      CMD_LOW_WRITE  = 3'd1,
      CMD_CPU_READ   = 3'd2,
      CMD_PPU_READ   = 3'd3,
      CMD_TICK       = 3'd4,
      CMD_SOFT_RESET = 3'd5
   } command_type;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_PRG      = 3'd1,
      KIND_WRAM     = 3'd2,
      KIND_REG_DATA = 3'd3,
      KIND_CHR      = 3'd4
   } access_kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_BOARD_VARIANT = 2'd0,
      CSR_CHR_MODE      = 2'd1,
      CSR_WRAM_PRESENT  = 2'd2
   } csr_index_type;

   // mapper register group select
   typedef enum logic [1:0] {
      SEL_OUTER = 2'd0,
      SEL_MODE  = 2'd1,
      SEL_IRQ   = 2'd2,
      SEL_BANK  = 2'd3
   } reg_select_type;

   typedef enum logic [1:0] {
      CHR_1K       = 2'd0,
      CHR_2K       = 2'd1,
      CHR_1K_OUTER = 2'd2
   } chr_mode_type;

   typedef enum logic [1:0] {
      PRG_16K = 2'd0,
      PRG_32K = 2'd1,
      PRG_8K  = 2'd2
   } prg_mode_type;

   localparam logic [4:0]  PRG_MASK_MAPPER = 5'h1F;
   localparam logic [4:0]  PRG_MASK_BOARD  = 5'h0F;
   localparam logic [7:0]  MODE_RESET      = 8'h10;
   localparam logic [31:0] PRG_BANK_RESET  = 32'hFFFE_FDFC;
   localparam logic [63:0] CHR_BANK_RESET  = 64'h0706_0504_0302_0100;
   localparam logic [3:0]  LOW_WINDOW      = 4'h5;
   localparam logic [2:0]  WRAM_WINDOW     = 3'h3;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [3:0]  tick_cycles;
   } item_type;

   typedef struct packed {
      access_kind_type access_kind;
      logic [21:0]     mapped_address;
      logic [7:0]      read_data;
      logic [1:0]      mirroring;
      logic            irq_asserted;
   } result_type;

   typedef struct packed {
      logic       board_variant;
      logic [1:0] chr_mode;
      logic       wram_present;
   } cfg_type;

   typedef struct packed {
      logic [3:0][7:0] prg_bank;
      logic [7:0][7:0] chr_bank;
      logic [3:0][7:0] low_reg;
      logic [7:0]      mode;
      logic [7:0]      outer;
      logic [7:0]      dip;
   } bank_state_type;

   // four 2K chr banks use bank registers 0, 1, 6 and 7
   function automatic logic [2:0] chr_2k_select(input logic [1:0] quarter);
      logic [2:0] idx;
      unique case (quarter)
         2'd0: idx = 3'd0;
         2'd1: idx = 3'd1;
         2'd2: idx = 3'd6;
         2'd3: idx = 3'd7;
         default: idx = 3'd0;
      endcase
      return idx;
   endfunction

endpackage

[rtl/core/cbm_req_if.sv]
// cbm_req_if: bus item channel of the bank mapper
// plain valid/ready channel, no dependencies
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [3:0]  tick_cycles;

   modport source (output valid, command, address, write_data, tick_cycles, input ready);
   modport sink (input valid, command, address, write_data, tick_cycles, output ready);
endinterface

[rtl/core/cbm_rsp_if.sv]
// cbm_rsp_if: result channel of the bank mapper
// plain valid/ready channel, no dependencies
interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  access_kind;
   logic [21:0] mapped_address;
   logic [7:0]  read_data;
   logic [1:0]  mirroring;
   logic        irq_asserted;

   modport source (output valid, access_kind, mapped_address, read_data, mirroring,
                   irq_asserted, input ready);
   modport sink (input valid, access_kind, mapped_address, read_data, mirroring,
                 irq_asserted, output ready);
endinterface

[rtl/core/cbm_csr_if.sv]
// cbm_csr_if: configuration write channel of the bank mapper
// plain valid/ready channel, no dependencies
interface cbm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/cbm_regs.sv]
// cbm_regs: configuration, bank, mode, outer, low, dip and irq counter registers
// depends on cbm_pkg
module cbm_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  cbm_pkg::item_type      item,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data,
   output cbm_pkg::cfg_type        cfg,
   output cbm_pkg::bank_state_type banks,
   output logic [1:0]             mirroring_next,
   output logic                   irq_next
);
   import cbm_pkg::*;

   cfg_type        cfg_ff;
   bank_state_type banks_ff, banks_in;
   logic           irq_en_ff, irq_en_in;
   logic [16:0]    cnt_ff, cnt_in;
   logic           line_ff, line_in;

   logic [1:0]  sel;
   logic [4:0]  low5;
   logic [16:0] diff;
   logic [16:0] sum;

   assign sel  = cfg_ff.board_variant ? item.address[11:10] : item.address[9:8];
   assign low5 = item.address[4:0];
   assign diff = cnt_ff - {13'd0, item.tick_cycles};
   assign sum  = {1'b0, cnt_ff[15:0]} + {13'd0, item.tick_cycles};

   always_comb begin
      banks_in  = banks_ff;
      irq_en_in = irq_en_ff;
      cnt_in    = cnt_ff;
      line_in   = line_ff;
      if (advance) begin
         unique case (item.command)
            CMD_REG_WRITE: begin
               if (item.address[15]) begin
                  unique case (sel)
                     SEL_OUTER: banks_in.outer = item.write_data;
                     SEL_MODE:  banks_in.mode  = item.write_data;
                     SEL_IRQ: begin
                        if (item.address[0]) begin
                           irq_en_in = banks_ff.mode[7];
                           cnt_in    = {1'b0, item.write_data, cnt_ff[7:0]};
                        end else begin
                           cnt_in  = {1'b0, cnt_ff[15:8], item.write_data};
                           line_in = 1'b0;
                        end
                     end
                     SEL_BANK: begin
                        if (!low5[4]) begin
                           banks_in.prg_bank[low5[1:0]] = item.write_data;
                        end else if (!low5[3]) begin
                           banks_in.chr_bank[low5[2:0]] = item.write_data;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            CMD_LOW_WRITE: begin
               if (item.address[15:12] == LOW_WINDOW) begin
                  banks_in.low_reg[item.address[1:0]] = item.write_data;
               end
            end
            CMD_TICK: begin
               if (irq_en_ff && cnt_ff != 17'd0 && !cnt_ff[16]) begin
                  if (banks_ff.mode[6]) begin
                     // counting down, fires at zero or below
                     cnt_in = diff;
                     if (diff == 17'd0 || diff[16]) begin
                        line_in   = 1'b1;
                        irq_en_in = 1'b0;
                     end
                  end else begin
                     // counting up, fires on 16-bit wrap
                     cnt_in = {1'b0, sum[15:0]};
                     if (sum[16]) begin
                        line_in   = 1'b1;
                        irq_en_in = 1'b0;
                     end
                  end
               end
            end
            CMD_SOFT_RESET: begin
               banks_in.mode  = 8'd0;
               banks_in.outer = 8'd0;
               banks_in.dip   = banks_ff.dip + 8'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff.prg_bank <= PRG_BANK_RESET;
         banks_ff.chr_bank <= CHR_BANK_RESET;
         banks_ff.low_reg  <= '0;
         banks_ff.mode     <= MODE_RESET;
         banks_ff.outer    <= 8'd0;
         banks_ff.dip      <= 8'd0;
         irq_en_ff         <= 1'b0;
         cnt_ff            <= 17'd0;
         line_ff           <= 1'b0;
      end else begin
         banks_ff  <= banks_in;
         irq_en_ff <= irq_en_in;
         cnt_ff    <= cnt_in;
         line_ff   <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOARD_VARIANT: cfg_ff.board_variant <= csr_data[0];
            CSR_CHR_MODE:      cfg_ff.chr_mode      <= csr_data[1:0];
            CSR_WRAM_PRESENT:  cfg_ff.wram_present  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg            = cfg_ff;
   assign banks          = banks_ff;
   assign mirroring_next = banks_in.mode[1:0];
   assign irq_next       = line_in;
endmodule

[rtl/core/cbm_map.sv]
// cbm_map: address decode and bank mapping for cpu and ppu reads
// depends on cbm_pkg
module cbm_map (
   input  cbm_pkg::item_type       item,
   input  cbm_pkg::cfg_type        cfg,
   input  cbm_pkg::bank_state_type banks,
   input  logic [1:0]             mirroring_next,
   input  logic                   irq_next,
   output cbm_pkg::result_type     result
);
   import cbm_pkg::*;

   logic [15:0] a;
   logic [4:0]  prg_mask;
   logic [7:0]  bank16;
   logic [8:0]  base8k;
   logic [4:0]  off8k;
   logic [21:0] prg_addr;
   logic [7:0]  chr_sel_bank;
   logic [9:0]  chr_1k_bank;
   logic [21:0] chr_addr;
   logic        data_sel;

   assign a        = item.address;
   assign prg_mask = cfg.board_variant ? PRG_MASK_BOARD : PRG_MASK_MAPPER;
   assign bank16   = a[14] ? (banks.outer | {4'd0, prg_mask[4:1]}) : banks.outer;
   assign base8k   = {banks.outer, 1'b0} & ~{4'd0, prg_mask};
   assign off8k    = (a[14:13] == 2'd3) ? prg_mask : (banks.prg_bank[a[14:13]][4:0] & prg_mask);
   assign data_sel = cfg.board_variant ? a[10] : a[8];

   always_comb begin
      unique case (banks.mode[4:3])
         PRG_16K: prg_addr = {bank16, a[13:0]};
         PRG_32K: prg_addr = {banks.outer[7:1], a[14:0]};
         default: prg_addr = {base8k | {4'd0, off8k}, a[12:0]};
      endcase
   end

   assign chr_sel_bank = banks.chr_bank[chr_2k_select(a[12:11])];
   assign chr_1k_bank  = {(cfg.chr_mode == CHR_1K_OUTER) ? banks.outer[5:4] : 2'd0,
                          banks.chr_bank[a[12:10]]};

   always_comb begin
      if (cfg.chr_mode == CHR_2K) begin
         chr_addr = {3'd0, chr_sel_bank, a[10:0]};
      end else begin
         chr_addr = {2'd0, chr_1k_bank, a[9:0]};
      end
   end

   always_comb begin
      result.access_kind    = KIND_NONE;
      result.mapped_address = 22'd0;
      result.read_data      = 8'd0;
      result.mirroring      = mirroring_next;
      result.irq_asserted   = irq_next;
      unique case (item.command)
         CMD_CPU_READ: begin
            priority if (a[15:12] == LOW_WINDOW) begin
               result.access_kind = KIND_REG_DATA;
               result.read_data   = data_sel ? banks.low_reg[a[1:0]] : banks.dip;
            end else if (a[15:13] == WRAM_WINDOW) begin
               if (cfg.wram_present) begin
                  result.access_kind    = KIND_WRAM;
                  result.mapped_address = {7'd0, banks.outer[7:6], a[12:0]};
               end else if (banks.mode[5]) begin
                  result.access_kind    = KIND_PRG;
                  result.mapped_address = {1'b0, banks.prg_bank[3], a[12:0]};
               end
            end else if (a[15]) begin
               result.access_kind    = KIND_PRG;
               result.mapped_address = prg_addr;
            end else begin
               // open bus below 5000 keeps the cleared defaults
            end
         end
         CMD_PPU_READ: begin
            result.access_kind    = KIND_CHR;
            result.mapped_address = chr_addr;
         end
         default: ;
      endcase
   end
endmodule

[rtl/core/cartridge_bank_mapper_irq.sv]
// cartridge_bank_mapper_irq: top level of the cartridge bank mapper with cycle irq
// depends on cbm_pkg, cbm_req_if, cbm_rsp_if, cbm_csr_if, cbm_regs, cbm_map
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    command, address, write_data, tick_cycles
//   rsp_ch    out   valid/ready    access_kind, mapped_address, read_data, mirroring,
//                                  irq_asserted
//   csr_ch    in    valid/ready    index, data (always ready)
//
// one word in, one word out, at one word per clock sustained while results are read
// each word passes the input register, then mapping/state update into the result register
// the result register parts the sides: a new word is taken into an empty input register while
// a result waits, and the input register stalls only when the result register is full and not being read
// synchronous active-high reset restores the power-on bank, mode and counter values
module cartridge_bank_mapper_irq (
   input logic       clock,
   input logic       reset,
   cbm_req_if.sink   req_ch,
   cbm_rsp_if.source rsp_ch,
   cbm_csr_if.sink   csr_ch
);
   import cbm_pkg::*;

   // input register stage
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;

   // result register stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic           out_free;
   logic           advance;
   logic           req_take;
   item_type       req_item;
   cfg_type        cfg;
   bank_state_type banks;
   logic [1:0]     mirroring_next;
   logic           irq_next;
   result_type     result;

   // result slot frees up when empty or being read this cycle
   assign out_free = !out_valid_ff || rsp_ch.ready;
   // the word in the input register moves on and updates mapper state
   assign advance  = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_item.command     = req_ch.command;
   assign req_item.address     = req_ch.address;
   assign req_item.write_data  = req_ch.write_data;
   assign req_item.tick_cycles = req_ch.tick_cycles;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // the user must land config writes only while idle, unenforced here; the port never back-pressures
   assign csr_ch.ready = 1'b1;

   // mapper state: banks, mode, outer, low regs, dip counter and irq counter
   cbm_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (s1_item_ff),
      .csr_we         (csr_ch.valid && csr_ch.ready),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .cfg            (cfg),
      .banks          (banks),
      .mirroring_next (mirroring_next),
      .irq_next       (irq_next)
   );

   // reads map against the state before the word; mirroring and irq are after it
   cbm_map u_map (
      .item           (s1_item_ff),
      .cfg            (cfg),
      .banks          (banks),
      .mirroring_next (mirroring_next),
      .irq_next       (irq_next),
      .result         (result)
   );

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.access_kind    = out_ff.access_kind;
   assign rsp_ch.mapped_address = out_ff.mapped_address;
   assign rsp_ch.read_data      = out_ff.read_data;
   assign rsp_ch.mirroring      = out_ff.mirroring;
   assign rsp_ch.irq_asserted   = out_ff.irq_asserted;
endmodule
